// ----- hw/rtl/prs_pkg.sv -----
// Package for the population rate loss scorer.
// Holds register indexes, fixed field widths, reset values and the
// command struct shared by the controller and the datapath.
package prs_pkg;

    // Field widths
    localparam int CountW = 13;
    localparam int RateW  = 32;
    localparam int LossW  = 48;
    localparam int TickW  = 31;
    localparam int DecayW = 16;
    localparam int ProdW  = 64;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 32;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_RATE_MIN     = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_RATE_MAX     = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DECAY_FACTOR = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_SPIKE_GAIN   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_NEW_CUT      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_FAM_CUT      = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_NEW_SLOPE    = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_FAM_SLOPE    = 3'd7;

    // Register reset values
    localparam logic [RateW-1:0]  RST_RATE_MIN     = 32'd0;
    localparam logic [RateW-1:0]  RST_RATE_MAX     = 32'd13107200;
    localparam logic [DecayW-1:0] RST_DECAY_FACTOR = 16'd65503;
    localparam logic [RateW-1:0]  RST_SPIKE_GAIN   = 32'd1600;
    localparam logic [RateW-1:0]  RST_NEW_CUT      = 32'd655360;
    localparam logic [RateW-1:0]  RST_FAM_CUT      = 32'd655360;
    localparam logic [RateW-1:0]  RST_NEW_SLOPE    = 32'd186413;
    localparam logic [RateW-1:0]  RST_FAM_SLOPE    = 32'd1677722;

    // Datapath step commands, one per controller state
    typedef struct packed {
        logic load;     // capture the input transaction and the base rate
        logic decay;    // multiply base rate by decay factor
        logic gain;     // keep decayed rate, multiply count by gain
        logic update;   // add, saturate, store new rate
        logic select;   // range check, pick slope and difference
        logic lmul;     // multiply slope by difference
        logic commit;   // accumulate loss, update tick, load result
    } prs_cmd_t;

endpackage

// ----- hw/rtl/prs_ctrl.sv -----
// Controller state machine of the population rate loss scorer.
// Sequences the datapath steps and owns both channel handshakes.
// Depends on prs_pkg for the command struct.
module prs_ctrl
    import prs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output prs_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECAY  = 3'd1;
    localparam logic [2:0] ST_GAIN   = 3'd2;
    localparam logic [2:0] ST_UPDATE = 3'd3;
    localparam logic [2:0] ST_SELECT = 3'd4;
    localparam logic [2:0] ST_LMUL   = 3'd5;
    localparam logic [2:0] ST_COMMIT = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       slot_free;

    // Result slot can take a new result when empty or being drained
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // Decode step commands
    always_comb
    begin
        cmd        = '0;
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.decay  = (state_reg == ST_DECAY);
        cmd.gain   = (state_reg == ST_GAIN);
        cmd.update = (state_reg == ST_UPDATE);
        cmd.select = (state_reg == ST_SELECT);
        cmd.lmul   = (state_reg == ST_LMUL);
        cmd.commit = (state_reg == ST_COMMIT) && slot_free;
    end

    // Advance through the steps; hold in commit until the slot frees up
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DECAY;
            ST_DECAY:  state_next = ST_GAIN;
            ST_GAIN:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_SELECT;
            ST_SELECT: state_next = ST_LMUL;
            ST_LMUL:   state_next = ST_COMMIT;
            ST_COMMIT: if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Set valid on commit, drop it when the result transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/prs_dp.sv -----
// Datapath of the population rate loss scorer: configuration registers,
// rate and loss state, one shared 32x32 multiplier and the result register.
// Depends on prs_pkg; driven by commands from prs_ctrl.
module prs_dp
    import prs_pkg::*;
#(
    parameter int NEURONS = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  prs_cmd_t            cmd,
    input  logic                cfg_write,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    input  logic [CountW-1:0]   spike_count,
    input  logic                scoring,
    input  logic                familiar_trial,
    output logic [RateW-1:0]    rate,
    output logic [LossW-1:0]    loss_total,
    output logic                in_range,
    output logic signed [31:0]  blowup_tick
);

    localparam logic [15:0] NeuronsW = 16'(NEURONS);

    // Configuration registers
    logic [RateW-1:0]  rate_min_reg;
    logic [RateW-1:0]  rate_max_reg;
    logic [DecayW-1:0] decay_reg;
    logic [RateW-1:0]  gain_reg;
    logic [RateW-1:0]  new_cut_reg;
    logic [RateW-1:0]  fam_cut_reg;
    logic [RateW-1:0]  new_slope_reg;
    logic [RateW-1:0]  fam_slope_reg;

    // Persistent state
    logic [RateW-1:0] rate_reg;
    logic [RateW-1:0] rate_next;
    logic             started_reg;
    logic [LossW-1:0] loss_reg;
    logic [LossW-1:0] loss_next;
    logic [TickW-1:0] tick_reg;
    logic [31:0]      blow_reg;
    logic [31:0]      blow_next;

    // Per-item working registers
    logic [CountW-1:0] cnt_reg;
    logic [CountW-1:0] cnt_next;
    logic              scoring_reg;
    logic              fam_reg;
    logic [RateW-1:0]  base_reg;
    logic [RateW-1:0]  base_next;
    logic [ProdW-1:0]  prod_reg;
    logic [RateW-1:0]  decayed_reg;
    logic              inside_reg;
    logic              inside_next;
    logic [RateW-1:0]  slope_reg;
    logic [RateW-1:0]  slope_next;
    logic [RateW-1:0]  diff_reg;
    logic [RateW-1:0]  diff_next;

    // Result register
    logic [RateW-1:0] res_rate_reg;
    logic [LossW-1:0] res_loss_reg;
    logic             res_inside_reg;
    logic [31:0]      res_blow_reg;

    // Shared multiplier
    logic [RateW-1:0] mul_a;
    logic [RateW-1:0] mul_b;
    logic [ProdW-1:0] mul_p;

    logic [RateW:0]   mid_sum;
    logic [45:0]      grow_sum;
    logic [LossW:0]   loss_sum;

    // Clamp the spike count to the population size
    always_comb
    begin
        cnt_next = spike_count;
        if ({3'b000, spike_count} > NeuronsW)
        begin
            cnt_next = NeuronsW[CountW-1:0];
        end
    end

    // Start from the bounds midpoint on the first tick
    assign mid_sum   = {1'b0, rate_min_reg} + {1'b0, rate_max_reg};
    assign base_next = started_reg ? rate_reg : mid_sum[RateW:1];

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = slope_reg;
        mul_b = diff_reg;
        priority if (cmd.decay)
        begin
            mul_a = base_reg;
            mul_b = {16'd0, decay_reg};
        end
        else if (cmd.gain)
        begin
            mul_a = {{(RateW-CountW){1'b0}}, cnt_reg};
            mul_b = gain_reg;
        end
        else
        begin
            mul_a = slope_reg;
            mul_b = diff_reg;
        end
    end
    assign mul_p = mul_a * mul_b;

    // Grow the decayed rate and saturate at the top of 32 bits
    assign grow_sum  = {14'd0, decayed_reg} + prod_reg[45:0];
    assign rate_next = (grow_sum[45:32] != 14'd0) ? {RateW{1'b1}} : grow_sum[RateW-1:0];

    // Range check and loss term selection
    always_comb
    begin
        inside_next = (rate_reg > rate_min_reg) && (rate_reg < rate_max_reg);
        slope_next  = '0;
        diff_next   = '0;
        if (inside_next && scoring_reg)
        begin
            if (!fam_reg && (rate_reg >= new_cut_reg))
            begin
                slope_next = new_slope_reg;
                diff_next  = rate_reg - new_cut_reg;
            end
            else if (fam_reg && (rate_reg <= fam_cut_reg))
            begin
                slope_next = fam_slope_reg;
                diff_next  = fam_cut_reg - rate_reg;
            end
        end
    end

    // Accumulate loss with saturation, record blow-up tick
    assign loss_sum  = {1'b0, loss_reg} + {1'b0, prod_reg[ProdW-1:16]};
    assign loss_next = loss_sum[LossW] ? {LossW{1'b1}} : loss_sum[LossW-1:0];
    assign blow_next = inside_reg ? blow_reg : {1'b0, tick_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_min_reg  <= RST_RATE_MIN;
            rate_max_reg  <= RST_RATE_MAX;
            decay_reg     <= RST_DECAY_FACTOR;
            gain_reg      <= RST_SPIKE_GAIN;
            new_cut_reg   <= RST_NEW_CUT;
            fam_cut_reg   <= RST_FAM_CUT;
            new_slope_reg <= RST_NEW_SLOPE;
            fam_slope_reg <= RST_FAM_SLOPE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RATE_MIN:     rate_min_reg  <= cfg_data;
                REG_RATE_MAX:     rate_max_reg  <= cfg_data;
                REG_DECAY_FACTOR: decay_reg     <= cfg_data[DecayW-1:0];
                REG_SPIKE_GAIN:   gain_reg      <= cfg_data;
                REG_NEW_CUT:      new_cut_reg   <= cfg_data;
                REG_FAM_CUT:      fam_cut_reg   <= cfg_data;
                REG_NEW_SLOPE:    new_slope_reg <= cfg_data;
                REG_FAM_SLOPE:    fam_slope_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg    <= '0;
            started_reg <= 1'b0;
            loss_reg    <= '0;
            tick_reg    <= '0;
            blow_reg    <= '1;
        end
        else
        begin
            if (cmd.update)
            begin
                rate_reg    <= rate_next;
                started_reg <= 1'b1;
            end
            if (cmd.commit)
            begin
                if (inside_reg)
                begin
                    loss_reg <= loss_next;
                end
                blow_reg <= blow_next;
                tick_reg <= tick_reg + 1'b1;
            end
        end
    end

    // Working and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cnt_reg     <= cnt_next;
            scoring_reg <= scoring;
            fam_reg     <= familiar_trial;
            base_reg    <= base_next;
        end
        if (cmd.decay || cmd.gain || cmd.lmul)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.gain)
        begin
            decayed_reg <= prod_reg[47:16];
        end
        if (cmd.select)
        begin
            inside_reg <= inside_next;
            slope_reg  <= slope_next;
            diff_reg   <= diff_next;
        end
        if (cmd.commit)
        begin
            res_rate_reg   <= rate_reg;
            res_loss_reg   <= inside_reg ? loss_next : loss_reg;
            res_inside_reg <= inside_reg;
            res_blow_reg   <= blow_next;
        end
    end

    assign rate        = res_rate_reg;
    assign loss_total  = res_loss_reg;
    assign in_range    = res_inside_reg;
    assign blowup_tick = res_blow_reg;

endmodule

// ----- hw/rtl/population_rate_loss_scorer_core.sv -----
// Population rate loss scorer, top level. Each input transaction runs through
// the steps load, decay, gain, update, select, lmul and commit; commit waits for
// a free result slot. A new item is taken only after commit, as the steps share
// the one 32x32 multiplier (decay, gain and loss products in turn).
// Reset (rst_n low, asynchronous) restores register defaults, zero loss and
// tick index, blow-up tick -1, and empties the result slot.
module population_rate_loss_scorer_core
    import prs_pkg::*;
#(
    parameter int NEURONS = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [CountW-1:0]   spike_count,
    input  logic                scoring,
    input  logic                familiar_trial,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [RateW-1:0]    rate,
    output logic [LossW-1:0]    loss_total,
    output logic                in_range,
    output logic signed [31:0]  blowup_tick,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    prs_cmd_t cmd;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    prs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    prs_dp #(
        .NEURONS (NEURONS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .spike_count    (spike_count),
        .scoring        (scoring),
        .familiar_trial (familiar_trial),
        .rate           (rate),
        .loss_total     (loss_total),
        .in_range       (in_range),
        .blowup_tick    (blowup_tick)
    );

endmodule

// ----- hw/rtl/prs_checker.sv -----
// Port-level checker for the population rate loss scorer, bound to the top.
// Depends on prs_pkg for field widths.
module prs_checker
    import prs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic [CountW-1:0]   spike_count,
    input logic                scoring,
    input logic                familiar_trial,
    input logic                out_valid,
    input logic                out_ready,
    input logic [RateW-1:0]    rate,
    input logic [LossW-1:0]    loss_total,
    input logic                in_range,
    input logic signed [31:0]  blowup_tick,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [CfgIdxW-1:0]  cfg_index,
    input logic [CfgDataW-1:0] cfg_data
);

    // Hold a pending result until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rate) && $stable(loss_total))
        else $error("result dropped or changed while stalled");

    // Block is busy right after taking an item
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in flight");

    // A blown-up result carries a real tick index
    a_blow_tick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> !blowup_tick[31])
        else $error("blow-up result without a tick index");

    // In range means strictly above the lower bound, so never zero
    a_rate_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_range |-> rate != '0)
        else $error("in-range result with zero rate");

endmodule

bind population_rate_loss_scorer_core prs_checker u_prs_checker (.*);

// ----- verif/prs_rate_loss_checker.sv -----
// Checker for the population rate loss scorer: tracks the register file,
// predicts rate, loss and blow-up tick per tick and compares each result.
// Depends on prs_pkg for field widths, register indexes and reset values.
module prs_rate_loss_checker
    import prs_pkg::*;
#(
    parameter int NEURONS = 4096
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [CountW-1:0]   spike_count,
    input  logic                scoring,
    input  logic                familiar_trial,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic [RateW-1:0]    rate,
    input  logic [LossW-1:0]    loss_total,
    input  logic                in_range,
    input  logic signed [31:0]  blowup_tick,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [RateW-1:0] RATE_SAT = '1;
    localparam logic [LossW-1:0] LOSS_SAT = '1;

    typedef struct {
        logic [RateW-1:0]   rate;
        logic [LossW-1:0]   loss;
        logic               in_range;
        logic signed [31:0] blowup;
    } tick_result_t;

    // Register copies
    logic [RateW-1:0]  rate_lo, rate_hi, gain, new_cut_q, fam_cut_q;
    logic [RateW-1:0]  new_slope_q, fam_slope_q;
    logic [DecayW-1:0] decay;

    // Scorer state
    logic [RateW-1:0]   rate_est;
    logic               started;
    logic [LossW-1:0]   loss_acc;
    logic [TickW-1:0]   tick_num;
    logic signed [31:0] last_blowup;

    tick_result_t expected_results[$];
    int           mismatches;

    // Accumulate slope * difference in Q32.16, saturating at the top of 48 bits
    task automatic add_loss(input logic [RateW-1:0] slope, input logic [RateW-1:0] diff);
        logic [63:0] inc;
        logic [63:0] sum;
        inc = (64'(slope) * 64'(diff)) >> 16;
        sum = 64'(loss_acc) + inc;
        loss_acc = (sum > 64'(LOSS_SAT)) ? LOSS_SAT : sum[LossW-1:0];
    endtask

    // Advance the rate estimate and the loss by one tick
    task automatic score_tick(input logic [CountW-1:0] count_in, input logic score_on,
                              input logic familiar, output tick_result_t res);
        logic [32:0]       mid;
        logic [63:0]       next_rate;
        logic [CountW-1:0] count;
        logic              in_bounds;
        count = (count_in > NEURONS) ? CountW'(NEURONS) : count_in;
        // seed the estimate from the bounds midpoint on the first tick
        if (!started) begin
            mid = {1'b0, rate_lo} + {1'b0, rate_hi};
            rate_est = mid[32:1];
            started = 1'b1;
        end
        next_rate = (64'(rate_est) * 64'(decay)) >> 16;
        next_rate = next_rate + 64'(count) * 64'(gain);
        rate_est = (next_rate > 64'(RATE_SAT)) ? RATE_SAT : next_rate[RateW-1:0];
        in_bounds = (rate_est > rate_lo) && (rate_est < rate_hi);
        if (!in_bounds) begin
            last_blowup = {1'b0, tick_num};
        end
        else if (score_on) begin
            if (!familiar) begin
                if (rate_est >= new_cut_q)
                    add_loss(new_slope_q, rate_est - new_cut_q);
            end
            else if (rate_est <= fam_cut_q) begin
                add_loss(fam_slope_q, fam_cut_q - rate_est);
            end
        end
        tick_num = tick_num + 1'b1;
        res.rate     = rate_est;
        res.loss     = loss_acc;
        res.in_range = in_bounds;
        res.blowup   = last_blowup;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        tick_result_t want;
        tick_result_t got;
        if (!rst_n)
        begin
            rate_lo     = RST_RATE_MIN;
            rate_hi     = RST_RATE_MAX;
            decay       = RST_DECAY_FACTOR;
            gain        = RST_SPIKE_GAIN;
            new_cut_q   = RST_NEW_CUT;
            fam_cut_q   = RST_FAM_CUT;
            new_slope_q = RST_NEW_SLOPE;
            fam_slope_q = RST_FAM_SLOPE;
            rate_est    = '0;
            started     = 1'b0;
            loss_acc    = '0;
            tick_num    = '0;
            last_blowup = -1;
            expected_results.delete();
            mismatches  = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // Compare the result transaction against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no tick outstanding, rate %0h", rate);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.rate !== rate)
                    begin
                        $error("rate: expected %0h actual %0h", want.rate, rate);
                        mismatches++;
                    end
                    if (want.loss !== loss_total)
                    begin
                        $error("loss_total: expected %0h actual %0h", want.loss, loss_total);
                        mismatches++;
                    end
                    if (want.in_range !== in_range)
                    begin
                        $error("in_range: expected %0b actual %0b", want.in_range, in_range);
                        mismatches++;
                    end
                    if (want.blowup !== blowup_tick)
                    begin
                        $error("blowup_tick: expected %0d actual %0d", want.blowup, blowup_tick);
                        mismatches++;
                    end
                end
            end

            // Predict each accepted tick transaction
            if (in_valid && in_ready)
            begin
                score_tick(spike_count, scoring, familiar_trial, got);
                expected_results.push_back(got);
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RATE_MIN:     rate_lo     = cfg_data;
                    REG_RATE_MAX:     rate_hi     = cfg_data;
                    REG_DECAY_FACTOR: decay       = cfg_data[DecayW-1:0];
                    REG_SPIKE_GAIN:   gain        = cfg_data;
                    REG_NEW_CUT:      new_cut_q   = cfg_data;
                    REG_FAM_CUT:      fam_cut_q   = cfg_data;
                    REG_NEW_SLOPE:    new_slope_q = cfg_data;
                    REG_FAM_SLOPE:    fam_slope_q = cfg_data;
                    default:          ;
                endcase
            end

            fail_count <= mismatches;
            pending    <= expected_results.size();
        end
    end

endmodule

// ----- verif/population_rate_loss_scorer_core_tb.sv -----
// Testbench top for the population rate loss scorer: clock, reset, tick and
// register stimulus with random idling, and the final verdict.
// Depends on prs_pkg, the core and prs_rate_loss_checker.
module population_rate_loss_scorer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import prs_pkg::*;

    localparam int NEURONS         = 4096;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int TICKS_PER_PHASE = 120;
    localparam int RANDOM_PHASES   = 8;
    localparam int QUIET_PHASE     = 3;
    localparam int DRAIN_CYCLES    = 16;
    localparam int IDLE_PCT        = 16;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic [CountW-1:0]   spike_count    = '0;
    logic                scoring        = 1'b0;
    logic                familiar_trial = 1'b0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic [RateW-1:0]    rate;
    logic [LossW-1:0]    loss_total;
    logic                in_range;
    logic signed [31:0]  blowup_tick;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index      = REG_RATE_MIN;
    logic [CfgDataW-1:0] cfg_data       = '0;
    int                  fail_count;
    int                  pending;
    bit                  gaps_on        = 1'b1;
    int                  cycle_count    = 0;

    population_rate_loss_scorer_core #(.NEURONS(NEURONS)) DUT (.*);

    prs_rate_loss_checker #(.NEURONS(NEURONS)) u_checker (.*);

    always #5ns clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Present one tick transaction and hold it until accepted
    task automatic send_tick(input logic [CountW-1:0] count, input logic score_on,
                             input logic familiar);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        spike_count    <= count;
        scoring        <= score_on;
        familiar_trial <= familiar;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Present one register write and hold it until accepted
    task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [CfgDataW-1:0] data);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Write the whole register file; upper bits of the decay word are junk
    task automatic write_settings(input logic [31:0] lo, input logic [31:0] hi,
                                  input logic [DecayW-1:0] decay, input logic [31:0] gain,
                                  input logic [31:0] ncut, input logic [31:0] fcut,
                                  input logic [31:0] nslope, input logic [31:0] fslope);
        write_reg(REG_RATE_MIN, lo);
        write_reg(REG_RATE_MAX, hi);
        write_reg(REG_DECAY_FACTOR, {16'($urandom()), decay});
        write_reg(REG_SPIKE_GAIN, gain);
        write_reg(REG_NEW_CUT, ncut);
        write_reg(REG_FAM_CUT, fcut);
        write_reg(REG_NEW_SLOPE, nslope);
        write_reg(REG_FAM_SLOPE, fslope);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] wild_value();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Spike counts mostly around the mean, sometimes anything the field holds
    function automatic logic [CountW-1:0] pick_count(input longint unsigned mean);
        longint unsigned span;
        span = 2 * mean + 1;
        if (span > 8191)
            span = 8191;
        if ($urandom_range(0, 99) < 85)
            return CountW'($urandom_range(0, 32'(span)));
        return CountW'($urandom());
    endfunction

    // One register setting followed by a run of random ticks
    task automatic run_random_phase(input bit wild);
        logic [31:0]       lo, hi, gain, ncut, fcut, nslope, fslope;
        logic [DecayW-1:0] decay;
        longint unsigned   target, mean;
        if (!wild)
        begin
            lo     = $urandom_range(0, 2 * 65536);
            hi     = 65536 * $urandom_range(20, 200);
            decay  = DecayW'($urandom_range(40000, 65535));
            gain   = $urandom_range(1, 8 * 65536);
            ncut   = $urandom_range(lo, hi);
            fcut   = $urandom_range(lo, hi);
            nslope = $urandom_range(0, 1 << 25);
            fslope = $urandom_range(0, 1 << 25);
            // aim the equilibrium rate at a random point between the bounds
            target = $urandom_range(lo, hi);
            mean   = (target * (65536 - longint'(decay))) / (longint'(gain) * 65536);
            if (mean > NEURONS)
                mean = NEURONS;
        end
        else
        begin
            lo     = wild_value();
            hi     = wild_value();
            decay  = DecayW'(wild_value());
            gain   = wild_value();
            ncut   = wild_value();
            fcut   = wild_value();
            nslope = wild_value();
            fslope = wild_value();
            mean   = $urandom_range(0, 64);
        end
        write_settings(lo, hi, decay, gain, ncut, fcut, nslope, fslope);
        repeat (TICKS_PER_PHASE)
            send_tick(pick_count(mean), $urandom_range(0, 99) < 80, $urandom_range(0, 1));
        wait_results_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First tick seeds from a midpoint whose sum carries out of 32 bits;
        // an oversized count is clamped to the population size
        write_reg(REG_RATE_MIN, 32'h8000_0000);
        write_reg(REG_RATE_MAX, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_tick(13'd0, 1'b1, 1'b0);
        send_tick(13'h1FFF, 1'b1, 1'b1);
        send_tick(13'd0, 1'b1, 1'b0);
        wait_results_drained();

        // Rate equals the count: hit both cuts exactly and both bounds
        write_settings(32'd0, 32'd4096, 16'd0, 32'd1, 32'd100, 32'd100,
                       32'h0100_0000, 32'h0100_0000);
        send_tick(13'd100, 1'b1, 1'b0);
        send_tick(13'd99, 1'b1, 1'b0);
        send_tick(13'd150, 1'b1, 1'b0);
        send_tick(13'd100, 1'b1, 1'b1);
        send_tick(13'd101, 1'b1, 1'b1);
        send_tick(13'd50, 1'b1, 1'b1);
        send_tick(13'd50, 1'b0, 1'b1);
        send_tick(13'd0, 1'b1, 1'b1);
        send_tick(13'd4096, 1'b1, 1'b0);
        send_tick(13'd4095, 1'b1, 1'b0);
        send_tick(13'd5000, 1'b1, 1'b0);
        wait_results_drained();

        // Saturate the rate, then decay from the top with full-scale registers
        write_settings('0, '1, 16'hFFFF, '1, '0, '1, 32'd1, 32'd1);
        send_tick(13'd1, 1'b0, 1'b0);
        send_tick(13'd0, 1'b1, 1'b0);
        send_tick(13'd0, 1'b1, 1'b1);
        wait_results_drained();

        // Equal and then inverted bounds: every tick blows up
        write_settings(32'd1000, 32'd1000, 16'h8000, 32'd500, '0, '0, 32'd1, 32'd1);
        send_tick(13'd2, 1'b1, 1'b0);
        wait_results_drained();
        write_reg(REG_RATE_MIN, 32'd2000);
        cfg_valid <= 1'b0;
        send_tick(13'd3, 1'b1, 1'b1);
        wait_results_drained();

        // Random settings; wild full-range settings come last
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            gaps_on = (p != QUIET_PHASE);
            run_random_phase(p >= RANDOM_PHASES - 2);
        end
        gaps_on = 1'b1;

        // Drive the loss into saturation with full-scale slopes
        write_settings('0, '1, 16'd0, 32'd1, '0, 32'hFFFF_FFFE, '1, '1);
        send_tick(13'd1, 1'b1, 1'b1);
        send_tick(13'd1, 1'b1, 1'b1);
        send_tick(13'd1, 1'b1, 1'b1);
        send_tick(13'd1, 1'b1, 1'b0);
        wait_results_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
